// ----- rtl/core/kf2_pkg.sv -----
// kf2_pkg: shared types, constants and the step sequence of the two-state kalman filter
`timescale 1ns / 1ps

package kf2_pkg;

  localparam int DW        = 32;            // q16.16 word
  localparam int FB        = 16;            // fractional bits
  localparam int AW        = 5;             // scratch ram address bits
  localparam int RAM_DEPTH = 32;
  localparam int NUM_UOPS  = 48;
  localparam int STEP_W    = 6;
  localparam int DIV_STEPS = DW + FB;       // quotient bits of (x << FB) / v
  localparam int DIV_CNT_W = 6;
  localparam int CFG_W     = 3;

  typedef logic [AW-1:0]    addr_t;
  typedef logic [CFG_W-1:0] cfg_idx_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DIV
  } op_t;

  // operand: a configuration register or a scratch ram entry
  typedef struct packed {
    logic  is_cfg;
    addr_t idx;
  } opnd_t;

  typedef struct packed {
    op_t   op;
    opnd_t a;
    opnd_t b;
    addr_t dst;
  } uop_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_TRANS_00 = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_TRANS_01 = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_TRANS_10 = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_TRANS_11 = cfg_idx_t'(3);
  localparam cfg_idx_t CFG_QPOS     = cfg_idx_t'(4);
  localparam cfg_idx_t CFG_QVEL     = cfg_idx_t'(5);
  localparam cfg_idx_t CFG_RMEAS    = cfg_idx_t'(6);

  // scratch ram map, state entries first
  localparam addr_t A_M0  = addr_t'(0);
  localparam addr_t A_M1  = addr_t'(1);
  localparam addr_t A_P0  = addr_t'(2);
  localparam addr_t A_P1  = addr_t'(3);
  localparam addr_t A_P2  = addr_t'(4);
  localparam addr_t A_P3  = addr_t'(5);
  localparam addr_t A_Z   = addr_t'(6);
  localparam addr_t A_MB0 = addr_t'(7);
  localparam addr_t A_MB1 = addr_t'(8);
  localparam addr_t A_T00 = addr_t'(9);
  localparam addr_t A_T01 = addr_t'(10);
  localparam addr_t A_T10 = addr_t'(11);
  localparam addr_t A_T11 = addr_t'(12);
  localparam addr_t A_S00 = addr_t'(13);
  localparam addr_t A_S01 = addr_t'(14);
  localparam addr_t A_S10 = addr_t'(15);
  localparam addr_t A_S11 = addr_t'(16);
  localparam addr_t A_V   = addr_t'(17);
  localparam addr_t A_K0  = addr_t'(18);
  localparam addr_t A_K1  = addr_t'(19);
  localparam addr_t A_E   = addr_t'(20);
  localparam addr_t A_X   = addr_t'(21);

  localparam logic [DW-1:0] ONE = DW'(1) << FB;

  function automatic opnd_t rm(addr_t a);
    return '{1'b0, a};
  endfunction

  function automatic opnd_t cf(cfg_idx_t c);
    return '{1'b1, addr_t'(c)};
  endfunction

  function automatic uop_t uop_rom(step_t s);
    uop_t u;
    case (s)
      // predicted mean
      6'd0:  u = '{OP_MUL, cf(CFG_TRANS_00), rm(A_M0), A_X};
      6'd1:  u = '{OP_MUL, cf(CFG_TRANS_01), rm(A_M1), A_MB0};
      6'd2:  u = '{OP_ADD, rm(A_X), rm(A_MB0), A_MB0};
      6'd3:  u = '{OP_MUL, cf(CFG_TRANS_10), rm(A_M0), A_X};
      6'd4:  u = '{OP_MUL, cf(CFG_TRANS_11), rm(A_M1), A_MB1};
      6'd5:  u = '{OP_ADD, rm(A_X), rm(A_MB1), A_MB1};
      // t = a * p
      6'd6:  u = '{OP_MUL, cf(CFG_TRANS_00), rm(A_P0), A_X};
      6'd7:  u = '{OP_MUL, cf(CFG_TRANS_01), rm(A_P2), A_T00};
      6'd8:  u = '{OP_ADD, rm(A_X), rm(A_T00), A_T00};
      6'd9:  u = '{OP_MUL, cf(CFG_TRANS_00), rm(A_P1), A_X};
      6'd10: u = '{OP_MUL, cf(CFG_TRANS_01), rm(A_P3), A_T01};
      6'd11: u = '{OP_ADD, rm(A_X), rm(A_T01), A_T01};
      6'd12: u = '{OP_MUL, cf(CFG_TRANS_10), rm(A_P0), A_X};
      6'd13: u = '{OP_MUL, cf(CFG_TRANS_11), rm(A_P2), A_T10};
      6'd14: u = '{OP_ADD, rm(A_X), rm(A_T10), A_T10};
      6'd15: u = '{OP_MUL, cf(CFG_TRANS_10), rm(A_P1), A_X};
      6'd16: u = '{OP_MUL, cf(CFG_TRANS_11), rm(A_P3), A_T11};
      6'd17: u = '{OP_ADD, rm(A_X), rm(A_T11), A_T11};
      // s = t * a transposed
      6'd18: u = '{OP_MUL, rm(A_T00), cf(CFG_TRANS_00), A_X};
      6'd19: u = '{OP_MUL, rm(A_T01), cf(CFG_TRANS_01), A_S00};
      6'd20: u = '{OP_ADD, rm(A_X), rm(A_S00), A_S00};
      6'd21: u = '{OP_MUL, rm(A_T00), cf(CFG_TRANS_10), A_X};
      6'd22: u = '{OP_MUL, rm(A_T01), cf(CFG_TRANS_11), A_S01};
      6'd23: u = '{OP_ADD, rm(A_X), rm(A_S01), A_S01};
      6'd24: u = '{OP_MUL, rm(A_T10), cf(CFG_TRANS_00), A_X};
      6'd25: u = '{OP_MUL, rm(A_T11), cf(CFG_TRANS_01), A_S10};
      6'd26: u = '{OP_ADD, rm(A_X), rm(A_S10), A_S10};
      6'd27: u = '{OP_MUL, rm(A_T10), cf(CFG_TRANS_10), A_X};
      6'd28: u = '{OP_MUL, rm(A_T11), cf(CFG_TRANS_11), A_S11};
      6'd29: u = '{OP_ADD, rm(A_X), rm(A_S11), A_S11};
      // process noise and innovation variance
      6'd30: u = '{OP_ADD, rm(A_S00), cf(CFG_QPOS), A_S00};
      6'd31: u = '{OP_ADD, rm(A_S11), cf(CFG_QVEL), A_S11};
      6'd32: u = '{OP_ADD, rm(A_S00), cf(CFG_RMEAS), A_V};
      // gains and innovation
      6'd33: u = '{OP_DIV, rm(A_S00), rm(A_V), A_K0};
      6'd34: u = '{OP_DIV, rm(A_S10), rm(A_V), A_K1};
      6'd35: u = '{OP_SUB, rm(A_Z), rm(A_MB0), A_E};
      // corrected mean
      6'd36: u = '{OP_MUL, rm(A_K0), rm(A_E), A_X};
      6'd37: u = '{OP_ADD, rm(A_MB0), rm(A_X), A_M0};
      6'd38: u = '{OP_MUL, rm(A_K1), rm(A_E), A_X};
      6'd39: u = '{OP_ADD, rm(A_MB1), rm(A_X), A_M1};
      // corrected covariance
      6'd40: u = '{OP_MUL, rm(A_K0), rm(A_S00), A_X};
      6'd41: u = '{OP_SUB, rm(A_S00), rm(A_X), A_P0};
      6'd42: u = '{OP_MUL, rm(A_K0), rm(A_S01), A_X};
      6'd43: u = '{OP_SUB, rm(A_S01), rm(A_X), A_P1};
      6'd44: u = '{OP_MUL, rm(A_K1), rm(A_S00), A_X};
      6'd45: u = '{OP_SUB, rm(A_S10), rm(A_X), A_P2};
      6'd46: u = '{OP_MUL, rm(A_K1), rm(A_S01), A_X};
      6'd47: u = '{OP_SUB, rm(A_S11), rm(A_X), A_P3};
      default: u = '{OP_ADD, rm(A_X), rm(A_X), A_X};
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/core/kf2_ram.sv -----
// kf2_ram: generic ram, one write port and two registered read ports
`timescale 1ns / 1ps

module kf2_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/core/kalman_filter_2state_1meas.sv -----
// kalman_filter_2state_1meas: fixed point two-state kalman predict and correct step
//
//  port group   direction  handshake          payload
//  cfg_         in         cfg_we             cfg_index, cfg_wdata
//  in_          in         in_valid/in_stall  in_measurement
//  out_         out        out_valid/out_stall mean, covariance, singular, saturated
//
// one item runs 48 micro-ops through one shared multiply / add / divide unit:
// every micro-op passes the read, execute and write-back states; a gain
// division also runs the divider if the innovation variance is positive.
// after reset an init pass loads the initial state into the scratch ram,
// with in_stall high. a finished result waits in the output register; the
// next transfer may be accepted meanwhile, and the block holds at its end
// until the output is free.
`timescale 1ns / 1ps

module kalman_filter_2state_1meas
  import kf2_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_index,
  input  logic [DW-1:0]         cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [DW-1:0]  in_measurement,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [DW-1:0]  out_mean_pos,
  output logic signed [DW-1:0]  out_mean_vel,
  output logic signed [DW-1:0]  out_cov_00,
  output logic signed [DW-1:0]  out_cov_01,
  output logic signed [DW-1:0]  out_cov_10,
  output logic signed [DW-1:0]  out_cov_11,
  output logic                  out_singular,
  output logic                  out_saturated
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_EX,
    S_DIV,
    S_WB,
    S_DONE
  } state_t;

  localparam logic [2:0] INIT_LAST = 3'(A_P3);
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  state_t state_r;
  logic [2:0] init_cnt_r;
  step_t step_r;
  uop_t uop;

  // configuration registers
  logic signed [DW-1:0] t00_r, t01_r, t10_r, t11_r;
  logic [DW-2:0] qpos_r, qvel_r, rmeas_r;

  // scratch ram
  logic ram_we;
  addr_t ram_waddr;
  logic [DW-1:0] ram_wdata, rd_a, rd_b;

  // shared unit
  logic signed [DW-1:0] opa, opb;
  logic signed [2*DW-1:0] prod_r, prod_adj;
  logic signed [DW:0] sum_r;
  logic [DW+FB-1:0] div_q_r;
  logic [DW-2:0] div_rem_r, div_den_r;
  logic [DW-1:0] div_trial, a_mag;
  logic div_neg_r, div_zero_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [2*DW-FB-1:0] scaled;
  logic signed [DW-1:0] wb_val;
  logic wb_sat;

  // result shadow and flags
  logic signed [DW-1:0] res_m0_r, res_m1_r, res_p0_r, res_p1_r, res_p2_r, res_p3_r;
  logic sing_r, sat_r;

  logic in_xfer, out_xfer;

  assign uop      = uop_rom(step_r);
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  function automatic logic signed [DW-1:0] cfg_val(cfg_idx_t c, logic signed [DW-1:0] a,
      logic signed [DW-1:0] b, logic signed [DW-1:0] cc, logic signed [DW-1:0] d,
      logic [DW-2:0] qp, logic [DW-2:0] qv, logic [DW-2:0] rn);
    logic signed [DW-1:0] v;
    case (c)
      CFG_TRANS_00: v = a;
      CFG_TRANS_01: v = b;
      CFG_TRANS_10: v = cc;
      CFG_TRANS_11: v = d;
      CFG_QPOS:     v = {1'b0, qp};
      CFG_QVEL:     v = {1'b0, qv};
      CFG_RMEAS:    v = {1'b0, rn};
      default:      v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = uop.a.is_cfg
        ? cfg_val(uop.a.idx[CFG_W-1:0], t00_r, t01_r, t10_r, t11_r, qpos_r, qvel_r, rmeas_r)
        : rd_a;
    opb = uop.b.is_cfg
        ? cfg_val(uop.b.idx[CFG_W-1:0], t00_r, t01_r, t10_r, t11_r, qpos_r, qvel_r, rmeas_r)
        : rd_b;
    a_mag = opa[DW-1] ? DW'(-opa) : opa;
    div_trial = {div_rem_r, div_q_r[DW+FB-1]};
  end

  // write-back value: scale, round toward zero and clip
  always_comb begin
    prod_adj = prod_r + (prod_r[2*DW-1] ? (2*DW)'(ONE - 1'b1) : '0);
    scaled   = prod_adj[2*DW-1:FB];
    wb_val   = '0;
    wb_sat   = 1'b0;
    case (uop.op)
      OP_MUL: begin
        if (!(&scaled[2*DW-FB-1:DW-1]) && (|scaled[2*DW-FB-1:DW-1])) begin
          wb_sat = 1'b1;
          wb_val = scaled[2*DW-FB-1] ? VMIN : VMAX;
        end else begin
          wb_val = scaled[DW-1:0];
        end
      end
      OP_ADD, OP_SUB: begin
        if (sum_r[DW] != sum_r[DW-1]) begin
          wb_sat = 1'b1;
          wb_val = sum_r[DW] ? VMIN : VMAX;
        end else begin
          wb_val = sum_r[DW-1:0];
        end
      end
      OP_DIV: begin
        if (div_zero_r) begin
          wb_val = '0;
        end else if (div_neg_r) begin
          if ((|div_q_r[DW+FB-1:DW]) || (div_q_r[DW-1] && (|div_q_r[DW-2:0]))) begin
            wb_sat = 1'b1;
            wb_val = VMIN;
          end else begin
            wb_val = DW'(-div_q_r[DW-1:0]);
          end
        end else if (|div_q_r[DW+FB-1:DW-1]) begin
          wb_sat = 1'b1;
          wb_val = VMAX;
        end else begin
          wb_val = div_q_r[DW-1:0];
        end
      end
      default: wb_val = '0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = uop.dst;
    ram_wdata = wb_val;
    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = addr_t'(init_cnt_r);
        ram_wdata = (addr_t'(init_cnt_r) == A_P0) ? ONE : '0;
      end
      S_IDLE: begin
        ram_we    = in_xfer;
        ram_waddr = A_Z;
        ram_wdata = in_measurement;
      end
      S_WB: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  kf2_ram #(
    .WIDTH(DW),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (uop.a.idx),
    .raddr_b (uop.b.idx),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t00_r   <= DW'(65536);
      t01_r   <= DW'(131072);
      t10_r   <= '0;
      t11_r   <= DW'(65536);
      qpos_r  <= (DW-1)'(6554);
      qvel_r  <= '0;
      rmeas_r <= (DW-1)'(6554);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRANS_00: t00_r   <= cfg_wdata;
        CFG_TRANS_01: t01_r   <= cfg_wdata;
        CFG_TRANS_10: t10_r   <= cfg_wdata;
        CFG_TRANS_11: t11_r   <= cfg_wdata;
        CFG_QPOS:     qpos_r  <= cfg_wdata[DW-2:0];
        CFG_QVEL:     qvel_r  <= cfg_wdata[DW-2:0];
        CFG_RMEAS:    rmeas_r <= cfg_wdata[DW-2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      init_cnt_r <= '0;
      step_r     <= '0;
      div_cnt_r  <= '0;
      out_valid  <= 1'b0;
      sing_r     <= 1'b0;
      sat_r      <= 1'b0;
    end else begin
      // in the final state the output register is reloaded instead
      if (out_xfer && (state_r != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          init_cnt_r <= init_cnt_r + 3'd1;
          if (init_cnt_r == INIT_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            step_r  <= '0;
            sing_r  <= 1'b0;
            sat_r   <= 1'b0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_EX;
        S_EX: begin
          prod_r     <= opa * opb;
          sum_r      <= (uop.op == OP_SUB) ? ({opa[DW-1], opa} - {opb[DW-1], opb})
                                           : ({opa[DW-1], opa} + {opb[DW-1], opb});
          div_zero_r <= 1'b0;
          if (uop.op == OP_DIV) begin
            if (opb[DW-1] || (opb == '0)) begin
              div_zero_r <= 1'b1;
              sing_r     <= 1'b1;
              state_r    <= S_WB;
            end else begin
              div_q_r   <= {a_mag, {FB{1'b0}}};
              div_rem_r <= '0;
              div_den_r <= opb[DW-2:0];
              div_neg_r <= opa[DW-1];
              div_cnt_r <= '0;
              state_r   <= S_DIV;
            end
          end else begin
            state_r <= S_WB;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (div_trial >= {1'b0, div_den_r}) begin
            div_rem_r <= (DW-1)'(div_trial - {1'b0, div_den_r});
            div_q_r   <= {div_q_r[DW+FB-2:0], 1'b1};
          end else begin
            div_rem_r <= div_trial[DW-2:0];
            div_q_r   <= {div_q_r[DW+FB-2:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          if (wb_sat) begin
            sat_r <= 1'b1;
          end
          case (uop.dst)
            A_M0: res_m0_r <= wb_val;
            A_M1: res_m1_r <= wb_val;
            A_P0: res_p0_r <= wb_val;
            A_P1: res_p1_r <= wb_val;
            A_P2: res_p2_r <= wb_val;
            A_P3: res_p3_r <= wb_val;
            default: ;
          endcase
          if (step_r == step_t'(NUM_UOPS - 1)) begin
            state_r <= S_DONE;
          end else begin
            step_r  <= step_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            out_mean_pos  <= res_m0_r;
            out_mean_vel  <= res_m1_r;
            out_cov_00    <= res_p0_r;
            out_cov_01    <= res_p1_r;
            out_cov_10    <= res_p2_r;
            out_cov_11    <= res_p3_r;
            out_singular  <= sing_r;
            out_saturated <= sat_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input taken while a step is running");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final state");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r < DIV_CNT_W'(DIV_STEPS)))
    else $error("divider ran past its last quotient bit");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < step_t'(NUM_UOPS))
    else $error("sequencer stepped past the last micro-op");

endmodule

// ----- tb/tb.sv -----
// tb: self-checking regression bench for the two-state fixed point kalman filter
`timescale 1ns / 1ps

module tb;
  import kf2_pkg::*;

  typedef struct {
    logic [DW-1:0] mean_pos;
    logic [DW-1:0] mean_vel;
    logic [DW-1:0] cov_00;
    logic [DW-1:0] cov_01;
    logic [DW-1:0] cov_10;
    logic [DW-1:0] cov_11;
    logic          singular;
    logic          saturated;
  } kf_result_t;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint QONE = 64'sd65536;
  localparam int     NUM_CFG = 7;
  localparam cfg_idx_t CFG_UNUSED = cfg_idx_t'(7);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_W-1:0]     cfg_index = '0;
  logic [DW-1:0]        cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [DW-1:0] in_measurement = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DW-1:0] out_mean_pos, out_mean_vel;
  logic signed [DW-1:0] out_cov_00, out_cov_01, out_cov_10, out_cov_11;
  logic                 out_singular, out_saturated;

  kalman_filter_2state_1meas dut (.*);

  always #4 clk = ~clk;

  // filter model state
  logic [DW-1:0] reg_shadow [NUM_CFG];
  longint        est_mean [2];
  longint        est_cov [4];
  bit            clip_seen;
  kf_result_t    pending_results [$];
  int            mismatches = 0;
  int            burst_left = 0;
  int            hold_off = 0;

  function automatic longint clip(longint x);
    if (x > QMAX) begin
      clip_seen = 1'b1;
      return QMAX;
    end
    if (x < QMIN) begin
      clip_seen = 1'b1;
      return QMIN;
    end
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clip((a * b) / QONE);
  endfunction

  function automatic longint qadd(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return clip(a - b);
  endfunction

  function automatic longint sreg(cfg_idx_t i);
    return longint'($signed(reg_shadow[i]));
  endfunction

  function automatic longint ureg(cfg_idx_t i);
    return longint'({1'b0, reg_shadow[i][30:0]});
  endfunction

  function automatic kf_result_t kalman_step(logic signed [DW-1:0] meas);
    longint a, b, c, d, z, mb0, mb1, t00, t01, t10, t11, s00, s01, s10, s11;
    longint v, k0, k1, e;
    kf_result_t r;
    clip_seen = 1'b0;
    a = sreg(CFG_TRANS_00);
    b = sreg(CFG_TRANS_01);
    c = sreg(CFG_TRANS_10);
    d = sreg(CFG_TRANS_11);
    z = longint'(meas);
    mb0 = qadd(qmul(a, est_mean[0]), qmul(b, est_mean[1]));
    mb1 = qadd(qmul(c, est_mean[0]), qmul(d, est_mean[1]));
    t00 = qadd(qmul(a, est_cov[0]), qmul(b, est_cov[2]));
    t01 = qadd(qmul(a, est_cov[1]), qmul(b, est_cov[3]));
    t10 = qadd(qmul(c, est_cov[0]), qmul(d, est_cov[2]));
    t11 = qadd(qmul(c, est_cov[1]), qmul(d, est_cov[3]));
    s00 = qadd(qmul(t00, a), qmul(t01, b));
    s01 = qadd(qmul(t00, c), qmul(t01, d));
    s10 = qadd(qmul(t10, a), qmul(t11, b));
    s11 = qadd(qmul(t10, c), qmul(t11, d));
    s00 = qadd(s00, ureg(CFG_QPOS));
    s11 = qadd(s11, ureg(CFG_QVEL));
    v = qadd(s00, ureg(CFG_RMEAS));
    k0 = 0;
    k1 = 0;
    r.singular = (v <= 0);
    if (v > 0) begin
      k0 = clip((s00 * QONE) / v);
      k1 = clip((s10 * QONE) / v);
    end
    e = qsub(z, mb0);
    est_mean[0] = qadd(mb0, qmul(k0, e));
    est_mean[1] = qadd(mb1, qmul(k1, e));
    est_cov[0] = qsub(s00, qmul(k0, s00));
    est_cov[1] = qsub(s01, qmul(k0, s01));
    est_cov[2] = qsub(s10, qmul(k1, s00));
    est_cov[3] = qsub(s11, qmul(k1, s01));
    r.mean_pos = est_mean[0][31:0];
    r.mean_vel = est_mean[1][31:0];
    r.cov_00 = est_cov[0][31:0];
    r.cov_01 = est_cov[1][31:0];
    r.cov_10 = est_cov[2][31:0];
    r.cov_11 = est_cov[3][31:0];
    r.saturated = clip_seen;
    return r;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_CFG) reg_shadow[idx] = val;
  endtask

  task automatic write_all(logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] c,
                           logic [DW-1:0] d, logic [DW-1:0] qp, logic [DW-1:0] qv,
                           logic [DW-1:0] rn);
    write_reg(CFG_TRANS_00, a);
    write_reg(CFG_TRANS_01, b);
    write_reg(CFG_TRANS_10, c);
    write_reg(CFG_TRANS_11, d);
    write_reg(CFG_QPOS, qp);
    write_reg(CFG_QVEL, qv);
    write_reg(CFG_RMEAS, rn);
  endtask

  // one measurement transfer, with bursts and random gaps on the sender side
  task automatic send_measurement(logic signed [DW-1:0] m);
    int gap;
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_measurement <= m;
    do @(posedge clk); while (!(in_valid && !in_stall));
    in_valid <= 1'b0;
    pending_results.push_back(kalman_step(m));
    burst_left--;
  endtask

  // let every result come back, then allow for the block's own latency
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] rand_meas();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return DW'($signed($urandom_range(0, 2097151)) - 1048576);
      default: return DW'($signed($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_trans();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return DW'($signed($urandom_range(0, 163840)) - 81920);
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_noise();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h0;
      2: return 32'hffffffff;
      default: return $urandom_range(0, 131072);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_measurement(32'sd0);
    send_measurement(32'sd65536);
    send_measurement(32'sh7fffffff);
    send_measurement(32'sh80000000);
    send_measurement(-32'sd1);
    send_measurement(32'sd1);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_measurement(32'sh7fffffff);
    send_measurement(32'sh80000000);
    wait_drained();
    // top bit of the noise registers is not part of the value
    write_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'hffffffff, 32'h80000001);
    send_measurement(32'sh80000000);
    send_measurement(32'sd12345);
    wait_drained();
    write_all(32'h00010000, 32'h00000000, 32'h00000000, 32'h00010000,
              32'h00001000, 32'h00000100, 32'h00002000);
    // writes beyond the register list change nothing
    write_reg(CFG_UNUSED, 32'hdeadbeef);
    send_measurement(32'sd131072);
    send_measurement(-32'sd65536);
    wait_drained();
  endtask

  task automatic test_singular_variance();
    // zero first row and zero position and measurement noise leave an innovation variance of zero
    write_all(32'h0, 32'h0, 32'h00008000, 32'h00010000, 32'h0, 32'h00000400, 32'h0);
    send_measurement(32'sd65536);
    send_measurement(-32'sd5);
    send_measurement(32'sh7fffffff);
    wait_drained();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0)
        write_all(32'h00010000, 32'h00020000, 32'h0, 32'h00010000, 32'd6554, 32'h0,
                  32'd6554);
      else
        write_all(rand_trans(), rand_trans(), rand_trans(), rand_trans(),
                  rand_noise(), rand_noise(), rand_noise());
      repeat (190) send_measurement(rand_meas());
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    hold_off = 3000;
    repeat (8) send_measurement(rand_meas());
    wait_drained();
  endtask

  // receiver: a randomly chosen stall pattern, switched when its random span runs out, with long hold-offs on request
  initial begin
    int mode;
    int span;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(100, 600);
      end
      span--;
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off--;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 15) != 0);
        endcase
      end
    end
  end

  task automatic check_field(string name, logic [DW-1:0] exp_v, logic [DW-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    kf_result_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        mismatches++;
      end else begin
        r = pending_results.pop_front();
        check_field("mean_pos", r.mean_pos, out_mean_pos);
        check_field("mean_vel", r.mean_vel, out_mean_vel);
        check_field("cov_00", r.cov_00, out_cov_00);
        check_field("cov_01", r.cov_01, out_cov_01);
        check_field("cov_10", r.cov_10, out_cov_10);
        check_field("cov_11", r.cov_11, out_cov_11);
        check_field("singular", DW'(r.singular), DW'(out_singular));
        check_field("saturated", DW'(r.saturated), DW'(out_saturated));
      end
    end
  end

  initial begin
    #40ms;
    $display("kalman_filter_2state_1meas regression: fail");
    $finish;
  end

  initial begin
    reg_shadow = '{32'd65536, 32'd131072, 32'd0, 32'd65536, 32'd6554, 32'd0, 32'd6554};
    est_mean = '{0, 0};
    est_cov = '{QONE, 0, 0, 0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_singular_variance();
    test_backpressure();
    test_random_settings();
    test_backpressure();
    wait_drained();
    if (mismatches == 0)
      $display("kalman_filter_2state_1meas regression: pass");
    else
      $display("kalman_filter_2state_1meas regression: fail");
    $finish;
  end

endmodule
